// File: src/mtrr_pkg.sv
package mtrr_pkg;

   localparam int MAX_RANGES_DEFAULT = 16;

   localparam int FRAME_W = 40;
   localparam int PAGE_W = 18;
   localparam int KIND_W = 8;
   localparam int ADDR_W = 52;
   localparam int LAST_W = 53;
   localparam int FRAME_SHIFT = 12;
   localparam int PAGE_SHIFT = 21;
   localparam int PAGE_ADDR_W = PAGE_W + PAGE_SHIFT;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 16;

   localparam logic [KIND_W-1:0] TYPE_UNCACHEABLE = 8'd0;
   localparam logic [KIND_W-1:0] TYPE_WRITE_BACK = 8'd6;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_ZERO_MASK = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ITEM_LOAD_SKIP,
      ITEM_LOAD_ZERO,
      ITEM_LOAD_STORE,
      ITEM_QUERY_ZERO,
      ITEM_QUERY
   } item_class_type;

   typedef struct packed {
      item_class_type kind_class;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] span;
      logic [KIND_W-1:0] mem_kind;
      logic [PAGE_W-1:0] page;
   } item_type;

endpackage

// File: src/mtrr_front.sv
module mtrr_front
   import mtrr_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  q_full,
   output logic                  q_push,
   output item_type              q_item
);

   logic [FRAME_W-1:0] base_frame;
   logic [FRAME_W-1:0] mask_frame;
   logic range_valid;
   logic [KIND_W-1:0] range_type;
   logic [PAGE_W-1:0] page_number;
   logic [FRAME_W-1:0] low_minus_one;

   assign base_frame = req_tdata[39:0];
   assign mask_frame = req_tdata[79:40];
   assign range_valid = req_tdata[80];
   assign range_type = req_tdata[88:81];
   assign page_number = req_tdata[106:89];

   assign low_minus_one = (mask_frame ^ (mask_frame - FRAME_W'(1))) >> 1;

   assign req_tready = !q_full;
   assign q_push = req_tvalid && !q_full;

   always_comb begin
      q_item.start = {base_frame, {FRAME_SHIFT{1'b0}}};
      q_item.span = {low_minus_one, {FRAME_SHIFT{1'b1}}};
      q_item.mem_kind = range_type;
      q_item.page = page_number;
      if (req_tuser) begin
         if (page_number == '0) begin
            q_item.kind_class = ITEM_QUERY_ZERO;
         end else begin
            q_item.kind_class = ITEM_QUERY;
         end
      end else if (!range_valid || range_type == TYPE_WRITE_BACK) begin
         q_item.kind_class = ITEM_LOAD_SKIP;
      end else if (mask_frame == '0) begin
         q_item.kind_class = ITEM_LOAD_ZERO;
      end else begin
         q_item.kind_class = ITEM_LOAD_STORE;
      end
   end

endmodule

// File: src/mtrr_queue.sv
module mtrr_queue
   import mtrr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type pop_item
);

   item_type slot_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10: count_ff <= count_ff + 2'd1;
            2'b01: count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: src/mtrr_back.sv
module mtrr_back
   import mtrr_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   state_type state_ff;
   item_type cur_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] scan_idx_ff;
   logic pend_ff;
   logic [KIND_W-1:0] kind_ff;
   logic rsp_valid_ff;
   logic [KIND_W-1:0] rsp_type_ff;
   status_type rsp_status_ff;

   logic [ADDR_W-1:0] range_start_ff [MAX_RANGES];
   logic [LAST_W-1:0] range_last_ff [MAX_RANGES];
   logic [KIND_W-1:0] range_kind_ff [MAX_RANGES];
   logic [ADDR_W-1:0] rd_start_ff;
   logic [LAST_W-1:0] rd_last_ff;
   logic [KIND_W-1:0] rd_kind_ff;

   logic [LAST_W-1:0] new_last;
   logic table_full;
   logic do_write;
   logic issue;
   logic [PAGE_ADDR_W-1:0] page_first;
   logic [PAGE_ADDR_W-1:0] page_last;
   logic hit;

   assign q_pop = (state_ff == ST_IDLE) && q_valid && !rsp_valid_ff;
   assign new_last = {1'b0, cur_ff.start} + {1'b0, cur_ff.span};
   assign table_full = (count_ff == CNT_W'(MAX_RANGES));
   assign do_write = (state_ff == ST_EXEC) && (cur_ff.kind_class == ITEM_LOAD_STORE)
                     && !table_full;
   assign issue = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);
   assign page_first = {cur_ff.page, {PAGE_SHIFT{1'b0}}};
   assign page_last = {cur_ff.page, {PAGE_SHIFT{1'b1}}};
   assign hit = pend_ff && (LAST_W'(page_first) <= rd_last_ff)
                && (ADDR_W'(page_last) >= rd_start_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - KIND_W - 2){1'b0}}, rsp_status_ff, rsp_type_ff};

   always_ff @(posedge clock) begin
      if (do_write) begin
         range_start_ff[count_ff[IDX_W-1:0]] <= cur_ff.start;
         range_last_ff[count_ff[IDX_W-1:0]] <= new_last;
         range_kind_ff[count_ff[IDX_W-1:0]] <= cur_ff.mem_kind;
      end
      rd_start_ff <= range_start_ff[scan_idx_ff[IDX_W-1:0]];
      rd_last_ff <= range_last_ff[scan_idx_ff[IDX_W-1:0]];
      rd_kind_ff <= range_kind_ff[scan_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         scan_idx_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  cur_ff <= q_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_type_ff <= TYPE_UNCACHEABLE;
               case (cur_ff.kind_class)
                  ITEM_LOAD_ZERO: begin
                     rsp_status_ff <= STATUS_ZERO_MASK;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
                  ITEM_LOAD_STORE: begin
                     if (table_full) begin
                        rsp_status_ff <= STATUS_FULL;
                     end else begin
                        rsp_status_ff <= STATUS_OK;
                        count_ff <= count_ff + CNT_W'(1);
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
                  ITEM_QUERY: begin
                     rsp_status_ff <= STATUS_OK;
                     scan_idx_ff <= '0;
                     pend_ff <= 1'b0;
                     kind_ff <= TYPE_WRITE_BACK;
                     state_ff <= ST_SCAN;
                  end
                  default: begin
                     rsp_status_ff <= STATUS_OK;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_SCAN: begin
               if (issue) begin
                  scan_idx_ff <= scan_idx_ff + CNT_W'(1);
               end
               if (hit && rd_kind_ff == TYPE_UNCACHEABLE) begin
                  rsp_type_ff <= TYPE_UNCACHEABLE;
                  rsp_status_ff <= STATUS_OK;
                  rsp_valid_ff <= 1'b1;
                  pend_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  pend_ff <= issue;
                  if (hit) begin
                     kind_ff <= rd_kind_ff;
                  end
                  if (!pend_ff && !issue) begin
                     rsp_type_ff <= kind_ff;
                     rsp_status_ff <= STATUS_OK;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANGES))
      else $error("range count exceeds table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_idx_ff <= count_ff)
      else $error("scan index beyond stored ranges");

   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid_ff)
      else $error("item started while a word is still pending");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != ST_IDLE)
      else $error("word produced without an item in progress");

endmodule

// File: src/mtrr_page_memory_type_resolver_core.sv
// Memory type resolver for 2MB pages built from variable-range MTRR pairs.
// The request stream carries one word per item. req_tuser selects the
// operation: low loads one base/mask pair, high queries the type of a page.
// Every request produces exactly one response word, in request order, that
// holds the resolved memory type (zero for loads) and a status code.
// A front stage classifies each word and pushes it into a two-entry queue;
// a back stage pops the queue and updates or scans the range table.
// A load, or a query of page zero, is answered straight from the execute state.
// Any other query scans the stored ranges: the back stage compares one table
// entry per cycle and stops early at an uncacheable hit. The back stage takes
// the next item only after the previous response has been taken.
// The front keeps accepting words while the queue has room, even when a
// response waits in the output register. When the receiver stalls, the back
// stage holds off popping the queue, so the queue fills and req_tready drops.
// Reset empties the range table and the queue and clears the response.
module mtrr_page_memory_type_resolver_core
   import mtrr_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // operation
   input  logic                  req_tuser,
   // base_frame, mask_frame, range_valid, range_type, page_number, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // memory_type, status, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_valid;
   item_type push_item;
   item_type pop_item;

   mtrr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   mtrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   mtrr_back #(
      .MAX_RANGES (MAX_RANGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/sv/mtrr_page_memory_type_resolver_core_tb.sv
module mtrr_page_memory_type_resolver_core_tb
   import mtrr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int RANDOM_ITEMS = 1180;
   localparam int TABLE_DEPTH = MAX_RANGES_DEFAULT;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [KIND_W-1:0] TYPE_WRITE_COMBINING = 8'd1;
   localparam logic [KIND_W-1:0] TYPE_WRITE_THROUGH = 8'd4;
   localparam logic [KIND_W-1:0] TYPE_WRITE_PROTECT = 8'd5;

   localparam int BASE_LO = 0;
   localparam int MASK_LO = BASE_LO + FRAME_W;
   localparam int VALID_BIT = MASK_LO + FRAME_W;
   localparam int KIND_LO = VALID_BIT + 1;
   localparam int PAGE_LO = KIND_LO + KIND_W;

   localparam logic [FRAME_W-1:0] FRAME_ALL = '1;
   localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

   typedef struct packed {
      logic [KIND_W-1:0] mem_type;
      status_type status;
   } rsp_fields_type;

   class memory_type_scoreboard;
      logic [63:0] range_first [TABLE_DEPTH];
      logic [63:0] range_end [TABLE_DEPTH];
      logic [KIND_W-1:0] range_mem [TABLE_DEPTH];
      int unsigned stored;
      rsp_fields_type expected_words[$];
      int unsigned mismatches;
      int unsigned responses;

      function new();
         stored = 0;
         mismatches = 0;
         responses = 0;
      endfunction

      function rsp_fields_type store_pair(logic [FRAME_W-1:0] base, logic [FRAME_W-1:0] mask,
                                          logic valid, logic [KIND_W-1:0] kind);
         rsp_fields_type word;
         int n;
         word.mem_type = '0;
         word.status = STATUS_OK;
         if (!valid || kind == TYPE_WRITE_BACK) return word;
         if (mask == '0) begin
            word.status = STATUS_ZERO_MASK;
            return word;
         end
         if (stored >= TABLE_DEPTH) begin
            word.status = STATUS_FULL;
            return word;
         end
         n = 0;
         while (!mask[n]) n++;
         range_first[stored] = {12'b0, base, 12'b0};
         range_end[stored] = range_first[stored] + ((64'd1 << (n + FRAME_SHIFT)) - 64'd1);
         range_mem[stored] = kind;
         stored++;
         return word;
      endfunction

      function rsp_fields_type resolve_page(logic [PAGE_W-1:0] page);
         rsp_fields_type word;
         logic [63:0] first;
         logic [63:0] last;
         word.status = STATUS_OK;
         word.mem_type = TYPE_WRITE_BACK;
         if (page == '0) begin
            word.mem_type = TYPE_UNCACHEABLE;
            return word;
         end
         first = {25'b0, page, 21'b0};
         last = first + 64'h1F_FFFF;
         for (int i = 0; i < stored; i++) begin
            if (first <= range_end[i] && last >= range_first[i]) begin
               word.mem_type = range_mem[i];
               if (word.mem_type == TYPE_UNCACHEABLE) break;
            end
         end
         return word;
      endfunction

      function void note_request(logic op, logic [REQ_DATA_W-1:0] data);
         if (op == OP_LOAD)
            expected_words.push_back(store_pair(data[BASE_LO +: FRAME_W],
               data[MASK_LO +: FRAME_W], data[VALID_BIT], data[KIND_LO +: KIND_W]));
         else
            expected_words.push_back(resolve_page(data[PAGE_LO +: PAGE_W]));
      endfunction

      function void flag(string what, logic [15:0] want, logic [15:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s in response %0d: expected %0h, got %0h",
                     what, responses, want, got);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         rsp_fields_type want;
         responses++;
         if (expected_words.size() == 0) begin
            flag("unrequested word", 16'h0, data);
            return;
         end
         want = expected_words.pop_front();
         if (data[7:0] !== want.mem_type) flag("memory_type", want.mem_type, data[7:0]);
         if (data[9:8] !== want.status) flag("status", want.status, data[9:8]);
      endfunction

      function logic [PAGE_W-1:0] page_near_range();
         int i;
         if (stored == 0) return PAGE_W'($urandom);
         i = $urandom_range(0, stored - 1);
         if ($urandom_range(0, 1) == 0) return range_first[i][PAGE_SHIFT +: PAGE_W];
         return range_end[i][PAGE_SHIFT +: PAGE_W];
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   memory_type_scoreboard sb = new();
   int unsigned cycles = 0;

   mtrr_page_memory_type_resolver_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
      end
   end

   function automatic logic [FRAME_W-1:0] rand_frame();
      return FRAME_W'({$urandom, $urandom});
   endfunction

   function automatic logic [FRAME_W-1:0] mask_from(int k);
      return FRAME_ALL << k;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(logic [FRAME_W-1:0] base,
         logic [FRAME_W-1:0] mask, logic valid, logic [KIND_W-1:0] kind,
         logic [PAGE_W-1:0] page);
      logic [REQ_DATA_W-1:0] data;
      data = '0;
      data[BASE_LO +: FRAME_W] = base;
      data[MASK_LO +: FRAME_W] = mask;
      data[VALID_BIT] = valid;
      data[KIND_LO +: KIND_W] = kind;
      data[PAGE_LO +: PAGE_W] = page;
      return data;
   endfunction

   function automatic int pick_gap(int idx);
      int r;
      if ((idx / 150) % 4 == 3) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [PAGE_W-1:0] pick_query_page();
      int r;
      logic [PAGE_W-1:0] page;
      r = $urandom_range(0, 99);
      if (r < 35) return PAGE_W'($urandom);
      if (r < 70) begin
         page = sb.page_near_range();
         case ($urandom_range(0, 3))
            0: return page - 1'b1;
            1: return page + 1'b1;
            default: return page;
         endcase
      end
      if (r < 85) return PAGE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 1))
         0: return PAGE_MAX;
         default: return PAGE_MAX - 1'b1;
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pick_load();
      int r;
      int k;
      logic [FRAME_W-1:0] base;
      logic [FRAME_W-1:0] mask;
      logic [KIND_W-1:0] kind;
      r = $urandom_range(0, 99);
      base = rand_frame();
      mask = rand_frame();
      kind = KIND_W'($urandom);
      if (r < 4) begin
         k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 39) : $urandom_range(9, 27);
         mask = mask_from(k);
         if ($urandom_range(0, 3) == 0) mask = mask | (rand_frame() << k);
         if ($urandom_range(0, 3) != 0) base = {13'b0, base[26:0]} & mask;
         case ($urandom_range(0, 4))
            0: kind = TYPE_UNCACHEABLE;
            1: kind = TYPE_WRITE_COMBINING;
            2: kind = TYPE_WRITE_THROUGH;
            3: kind = TYPE_WRITE_PROTECT;
            default: if (kind == TYPE_WRITE_BACK) kind = TYPE_WRITE_PROTECT;
         endcase
         return pack_request(base, mask, 1'b1, kind, PAGE_W'($urandom));
      end
      if (r < 20) begin
         if (kind == TYPE_WRITE_BACK) kind = TYPE_UNCACHEABLE;
         return pack_request(base, '0, 1'b1, kind, PAGE_W'($urandom));
      end
      if (r < 35) return pack_request(base, mask, 1'b1, TYPE_WRITE_BACK, PAGE_W'($urandom));
      return pack_request(base, mask, 1'b0, kind, PAGE_W'($urandom));
   endfunction

   task automatic send_word(input logic op, input logic [REQ_DATA_W-1:0] data, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int hold;
      int r;
      bit long_hold_done;
      hold = 0;
      long_hold_done = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && sb.responses >= 200) begin
            long_hold_done = 1;
            hold = 400;
            rsp_tready <= 1'b0;
         end else if ((sb.responses / 100) % 5 == 4) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               hold = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin
      int idx;
      idx = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(OP_QUERY, pack_request(rand_frame(), rand_frame(), 1'b1, 8'hFF, '0), 0);
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, PAGE_MAX), pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h200, mask_from(9), 1'b0, TYPE_UNCACHEABLE, PAGE_MAX),
                pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h200, mask_from(9), 1'b1, TYPE_WRITE_BACK, '0),
                pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h400, '0, 1'b1, TYPE_WRITE_COMBINING, '0),
                pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h200, mask_from(9), 1'b1, TYPE_WRITE_COMBINING, '0),
                pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, 18'd1), pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, 18'd2), pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h200, mask_from(9), 1'b1, TYPE_UNCACHEABLE, '0),
                pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h200, mask_from(9), 1'b1, TYPE_WRITE_PROTECT, '0),
                pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, 18'd1), pick_gap(idx));
      send_word(OP_LOAD, pack_request('0, mask_from(39), 1'b1, TYPE_WRITE_THROUGH, '0),
                pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, PAGE_MAX), pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, 18'd2), pick_gap(idx));
      send_word(OP_LOAD, pack_request(FRAME_ALL, FRAME_ALL, 1'b1, 8'hFF, '0), pick_gap(idx));
      send_word(OP_LOAD, pack_request('0, mask_from(0), 1'b1, 8'h80, '0), pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, '0), pick_gap(idx));
      send_word(OP_LOAD, pack_request(40'h3FF, mask_from(0), 1'b1, 8'h02, '0), pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, 18'd2), pick_gap(idx));
      send_word(OP_QUERY, pack_request('0, '0, 1'b0, '0, 18'd1), pick_gap(idx));
      send_word(OP_QUERY, pack_request(rand_frame(), rand_frame(), 1'b1, 8'hFF, PAGE_MAX - 1'b1),
                pick_gap(idx));

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if ($urandom_range(0, 99) < 55)
            send_word(OP_QUERY, pack_request(rand_frame(), rand_frame(), 1'($urandom),
                      KIND_W'($urandom), pick_query_page()), pick_gap(idx));
         else
            send_word(OP_LOAD, pick_load(), pick_gap(idx));
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
